[rtl/tnts_pkg.sv]
// Shared types, constants and functions for the toroidal nearest target search.
// Used by tnts_cell and toroidal_nearest_target_search; depends on nothing.

package tnts_pkg;

	localparam int GRID_SIZE_DEF   = 100;
	localparam int TABLE_DEPTH_DEF = 512;
	localparam int COORD_W         = 7;
	localparam int DIST_W          = 8;
	localparam int IDX_MAX_W       = 12;
	localparam int RADIUS_W        = 8;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 8'd40;

	// Request codes.
	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_BAD_INDEX = 2'd2;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [COORD_W-1:0] mod_lut_t [2**COORD_W];

	// One stored target.
	typedef struct packed {
		coord_t y;
		coord_t x;
	} entry_t;

	// Running best that travels down the row of cells.
	typedef struct packed {
		logic                 vld;
		logic                 found;
		logic [IDX_MAX_W-1:0] idx;
		dist_t                distance;
	} token_t;

	// Reduction table for coordinates, built at elaboration.
	function automatic mod_lut_t build_mod_lut(int g);
		mod_lut_t lut;
		int       v;
		for (int i = 0; i < 2**COORD_W; i++) begin
			v = i;
			for (int j = 0; j < 2**COORD_W; j++) begin
				if (v >= g) begin
					v = v - g;
				end
			end
			lut[i] = COORD_W'(v);
		end
		return lut;
	endfunction

	// Largest ladder rung not above the radius; zero when none applies.
	function automatic dist_t reach_of(logic [RADIUS_W-1:0] r);
		dist_t reach;
		reach = '0;
		if (r >= 8'd5)  reach = 8'd5;
		if (r >= 8'd10) reach = 8'd10;
		if (r >= 8'd20) reach = 8'd20;
		if (r >= 8'd30) reach = 8'd30;
		if (r >= 8'd40) reach = 8'd40;
		if (r >= 8'd50) reach = 8'd50;
		return reach;
	endfunction

endpackage

[rtl/tnts_cell.sv]
// One cell of the target row: holds one table entry and scores the passing word.
// Depends on tnts_pkg.

module tnts_cell #(
	parameter int GRID_SIZE = tnts_pkg::GRID_SIZE_DEF,
	parameter int CELL_IDX  = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_en,
	input  tnts_pkg::entry_t    load_data,
	input  logic                shift_en,
	input  tnts_pkg::entry_t    next_data,
	input  logic                in_range,
	input  tnts_pkg::coord_t    qx,
	input  tnts_pkg::coord_t    qy,
	input  tnts_pkg::dist_t     reach,
	input  tnts_pkg::token_t    tok_in,
	output tnts_pkg::entry_t    entry,
	output tnts_pkg::token_t    tok_out
);

	localparam logic [tnts_pkg::COORD_W-1:0] HALF  = tnts_pkg::COORD_W'(GRID_SIZE / 2);
	localparam logic [tnts_pkg::COORD_W:0]   GRID  = (tnts_pkg::COORD_W+1)'(GRID_SIZE);

	tnts_pkg::entry_t entry_q;
	tnts_pkg::token_t tok_q;
	tnts_pkg::coord_t dx_raw, dy_raw, dx, dy;
	tnts_pkg::dist_t  cand_dist;
	logic             better;
	tnts_pkg::token_t tok_nxt;

	// Entry storage: append loads, removal takes the neighbor's entry.
	always_ff @(posedge clk) begin
		if (load_en) begin
			entry_q <= load_data;
		end else if (shift_en) begin
			entry_q <= next_data;
		end
	end

	// Wrap-around Manhattan distance to the query point.
	always_comb begin
		dx_raw = (qx > entry_q.x) ? qx - entry_q.x : entry_q.x - qx;
		dy_raw = (qy > entry_q.y) ? qy - entry_q.y : entry_q.y - qy;
		dx = (dx_raw > HALF) ? tnts_pkg::COORD_W'(GRID - {1'b0, dx_raw}) : dx_raw;
		dy = (dy_raw > HALF) ? tnts_pkg::COORD_W'(GRID - {1'b0, dy_raw}) : dy_raw;
		cand_dist = {1'b0, dx} + {1'b0, dy};
		// Strictly nearer only, so the lowest index keeps a tie.
		better = in_range && (reach != '0) && (cand_dist <= reach)
			&& (!tok_in.found || cand_dist < tok_in.distance);
		tok_nxt = tok_in;
		if (better) begin
			tok_nxt.found    = 1'b1;
			tok_nxt.idx      = tnts_pkg::IDX_MAX_W'(CELL_IDX);
			tok_nxt.distance = cand_dist;
		end
	end

	// The word moves one cell per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign entry   = entry_q;
	assign tok_out = tok_q;

endmodule

[rtl/toroidal_nearest_target_search.sv]
// Top level of the toroidal nearest target search: request control and the cell row.
// Depends on tnts_pkg and tnts_cell.
//
// Channel   Signals                                   Direction
// in        in_valid/in_ready, req_type..entry_index  request words in
// out       out_valid/out_ready, found..status        result words out
// cfg       cfg_valid/cfg_ready, cfg_data             search_radius write
//
// Append, remove and other requests answer in the cycle after acceptance. A query
// passes the launch state, then the best-so-far word walks the cell row, one cell
// per cycle; the result is registered as it leaves the row. One request is in
// work at a time; a new request is taken once the output register is free. Reset
// clears the count and control state; table entries are undefined until appended.

module toroidal_nearest_target_search #(
	parameter int GRID_SIZE   = tnts_pkg::GRID_SIZE_DEF,
	parameter int TABLE_DEPTH = tnts_pkg::TABLE_DEPTH_DEF,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       req_type,
	input  logic [6:0]       pos_x,
	input  logic [6:0]       pos_y,
	input  logic [IDX_W-1:0] entry_index,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             found,
	output logic [IDX_W-1:0] nearest_index,
	output logic [6:0]       nearest_distance,
	output logic [CNT_W-1:0] entry_count,
	output logic [1:0]       status,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_data
);

	localparam tnts_pkg::mod_lut_t MOD_LUT = tnts_pkg::build_mod_lut(GRID_SIZE);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_LAUNCH = 2'd1;
	localparam logic [1:0] S_RUN    = 2'd2;

	logic [1:0]                      state_q;
	logic [7:0]                      radius_q;
	logic [CNT_W-1:0]                count_q;
	tnts_pkg::coord_t                qx_q, qy_q;
	tnts_pkg::dist_t                 reach_q;
	logic                            out_valid_q, found_q;
	logic [IDX_W-1:0]                idx_q;
	logic [6:0]                      dist_q;
	logic [CNT_W-1:0]                cnt_out_q;
	logic [1:0]                      status_q;
	logic                            accept;
	tnts_pkg::coord_t                px_red, py_red;
	tnts_pkg::entry_t                entries [TABLE_DEPTH];
	tnts_pkg::token_t                toks    [TABLE_DEPTH+1];
	logic                            do_append, do_remove;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign px_red    = MOD_LUT[pos_x];
	assign py_red    = MOD_LUT[pos_y];
	assign do_append = accept && (req_type == tnts_pkg::REQ_APPEND)
		&& (count_q < CNT_W'(TABLE_DEPTH));
	assign do_remove = accept && (req_type == tnts_pkg::REQ_REMOVE)
		&& ({1'b0, entry_index} < (IDX_W+1)'(count_q));

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= tnts_pkg::RADIUS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radius_q <= cfg_data;
		end
	end

	// Launch word for cell zero: valid for one cycle after a query is taken.
	assign toks[0] = '{vld: (state_q == S_LAUNCH), found: 1'b0, idx: '0, distance: '0};

	// Row of cells.
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		tnts_pkg::entry_t nxt;
		if (i == TABLE_DEPTH - 1) begin : g_last
			assign nxt = entries[i];
		end else begin : g_mid
			assign nxt = entries[i+1];
		end
		tnts_cell #(
			.GRID_SIZE (GRID_SIZE),
			.CELL_IDX  (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load_en   (do_append && (count_q == CNT_W'(i))),
			.load_data ('{y: py_red, x: px_red}),
			.shift_en  (do_remove && ((IDX_W+1)'(i) >= {1'b0, entry_index})),
			.next_data (nxt),
			.in_range  ((CNT_W+1)'(i) < {1'b0, count_q}),
			.qx        (qx_q),
			.qy        (qy_q),
			.reach     (reach_q),
			.tok_in    (toks[i]),
			.entry     (entries[i]),
			.tok_out   (toks[i+1])
		);
	end

	// Query point and reach, held while the word walks the row.
	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q    <= px_red;
			qy_q    <= py_red;
			reach_q <= tnts_pkg::reach_of(radius_q);
		end
	end

	// Request control, count and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_type == tnts_pkg::REQ_QUERY) begin
							state_q <= S_LAUNCH;
						end else begin
							out_valid_q <= 1'b1;
						end
						if (do_append) begin
							count_q <= count_q + 1'b1;
						end else if (do_remove) begin
							count_q <= count_q - 1'b1;
						end
					end
				end
				S_LAUNCH: begin
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (toks[TABLE_DEPTH].vld) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			found_q  <= 1'b0;
			idx_q    <= '0;
			dist_q   <= '0;
			status_q <= tnts_pkg::ST_OK;
			if (req_type == tnts_pkg::REQ_APPEND && !do_append) begin
				status_q <= tnts_pkg::ST_FULL;
			end
			if (req_type == tnts_pkg::REQ_REMOVE && !do_remove) begin
				status_q <= tnts_pkg::ST_BAD_INDEX;
			end
			if (do_append) begin
				cnt_out_q <= count_q + 1'b1;
			end else if (do_remove) begin
				cnt_out_q <= count_q - 1'b1;
			end else begin
				cnt_out_q <= count_q;
			end
		end else if (state_q == S_RUN && toks[TABLE_DEPTH].vld) begin
			found_q <= toks[TABLE_DEPTH].found;
			idx_q   <= IDX_W'(toks[TABLE_DEPTH].idx);
			dist_q  <= 7'(toks[TABLE_DEPTH].distance);
		end
	end

	assign out_valid        = out_valid_q;
	assign found            = found_q;
	assign nearest_index    = idx_q;
	assign nearest_distance = dist_q;
	assign entry_count      = cnt_out_q;
	assign status           = status_q;

endmodule
